// File: sv/walm_pkg.sv
// ----------------------------------------------------------------------------
// walm_pkg
// Shared types, codes and sizing constants of the group-commit log manager.
// ----------------------------------------------------------------------------
package walm_pkg;

    localparam int LOG_ENTRIES_DEF  = 30;
    localparam int DISKS_DEF        = 2;
    localparam int FIRST_DEVICE_DEF = 1;
    localparam int MAX_DISKS        = 4;
    localparam int NUM_REGS         = 5;

    localparam logic [2:0] OP_BEGIN  = 3'd0;
    localparam logic [2:0] OP_END    = 3'd1;
    localparam logic [2:0] OP_RECORD = 3'd2;
    localparam logic [2:0] OP_CDISK  = 3'd3;
    localparam logic [2:0] OP_CFIN   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WAIT      = 3'd1;
    localparam logic [2:0] ST_BADDEV    = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_ENDCOMMIT = 3'd5;
    localparam logic [2:0] ST_NOTCOMMIT = 3'd6;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_COPY    = 3'd1;
    localparam logic [2:0] CMD_HEAD    = 3'd2;
    localparam logic [2:0] CMD_INSTALL = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;
    localparam logic [2:0] CMD_PIN     = 3'd5;

    localparam logic [2:0] REG_LOG0 = 3'd0;
    localparam logic [2:0] REG_LOG1 = 3'd1;
    localparam logic [2:0] REG_LOG2 = 3'd2;
    localparam logic [2:0] REG_LOG3 = 3'd3;
    localparam logic [2:0] REG_MAXOP = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  device;
        logic [31:0] home_block;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        commit_required;
        logic [2:0]  command;
        logic [3:0]  command_device;
        logic [31:0] log_block;
        logic [31:0] target_block;
        logic [4:0]  entry_count;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COPY,
        S_INSTALL,
        S_EMIT
    } t_state;

endpackage

// File: sv/walm_ram.sv
// ----------------------------------------------------------------------------
// walm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module walm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/write_ahead_log_transaction_manager.sv
// ----------------------------------------------------------------------------
// write_ahead_log_transaction_manager
// Group-commit write-ahead log manager with per-disk dirty block lists.
// ----------------------------------------------------------------------------
// Input items arrive on i_in_valid/o_in_ready with a t_in_item payload; result
// transfers leave on o_out_valid/i_out_ready, the last one of an item flagged
// by its last field. Configuration is written through i_cfg_we/i_cfg_index/
// i_cfg_data while the block is idle; the user must keep to this, as the
// block itself does not enforce it. One item is handled at a time, and input
// is refused until its last result has been taken. Begin, end, commit finish
// and every error give one result, registered in the S_EMIT state that follows
// acceptance. A record write walks the disk's list in the block RAM, one entry
// per cycle, until it finds the block or reaches the fill count, then gives its
// result. A commit-disk item on a non-empty list reads the list twice, once for
// the copy commands and once for the install commands, giving 2 * entries_used
// + 2 results: each copy or install result is read and then emitted, header and
// clear are emitted directly. The single-entry output register holds a result
// while the receiver stalls and the list walk pauses. Reset clears the operation
// count, the commit flag, the per-disk fill counts and restores the
// configuration registers; list RAM contents are not cleared and need no
// clearing pass, as an entry is only read below the fill count.
// ----------------------------------------------------------------------------
module write_ahead_log_transaction_manager #(
    parameter int LOG_ENTRIES  = walm_pkg::LOG_ENTRIES_DEF,
    parameter int DISKS        = walm_pkg::DISKS_DEF,
    parameter int FIRST_DEVICE = walm_pkg::FIRST_DEVICE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  walm_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output walm_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import walm_pkg::*;

    localparam int SW    = 5;
    localparam int DW    = (DISKS > 1) ? $clog2(DISKS) : 1;
    localparam int DEPTH = DISKS * 32;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0] r_log_start [MAX_DISKS];
    logic [4:0]  r_max_op;
    logic [5:0]  r_open, n_open;
    logic        r_commit, n_commit;
    logic [SW-1:0] r_used [DISKS];
    t_state      r_state, n_state;
    t_in_item    r_item, n_item;
    logic [DW-1:0] r_disk, n_disk;
    logic [SW-1:0] r_idx, n_idx;
    logic        r_rd_pend, n_rd_pend;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_rdata;
    logic          used_we;
    logic [SW-1:0] used_wval;

    walm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_list (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(r_item.home_block),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !r_ov;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // device to disk decode
    logic          dev_ok;
    logic [DW-1:0] dev_disk;
    logic [4:0]    dev_off;
    always_comb begin
        dev_off  = 5'(r_item.device) - 5'(FIRST_DEVICE);
        dev_ok   = ({1'b0, r_item.device} >= 5'(FIRST_DEVICE)) &&
                   ({1'b0, r_item.device} < 5'(FIRST_DEVICE + DISKS));
        dev_disk = DW'(dev_off);
    end

    logic [SW-1:0] cur_used;
    assign cur_used = r_used[r_disk];
    logic [31:0]   base;
    assign base = r_log_start[2'(r_disk)];

    // begin admission: every disk needs room
    logic [11:0] need;
    logic        room;
    always_comb begin
        need = (12'(r_open) + 12'd1) * 12'(r_max_op);
        room = 1'b1;
        for (int d = 0; d < DISKS; d++) begin
            if (12'(r_used[d]) + need > 12'(LOG_ENTRIES)) begin
                room = 1'b0;
            end
        end
    end

    function automatic t_out_item mk(logic [2:0] st, logic rq, logic [2:0] cmd,
                                     logic [3:0] dv, logic [31:0] lb,
                                     logic [31:0] tb, logic [4:0] cn, logic ls);
        t_out_item o;
        o.status = st; o.commit_required = rq; o.command = cmd;
        o.command_device = dv; o.log_block = lb; o.target_block = tb;
        o.entry_count = cn; o.last = ls;
        return o;
    endfunction

    logic out_free;
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        n_state = r_state; n_item = r_item; n_disk = r_disk; n_idx = r_idx;
        n_rd_pend = 1'b0; n_open = r_open; n_commit = r_commit;
        n_ov = r_ov && !i_out_ready; n_out = r_out;
        ram_we = 1'b0; used_we = 1'b0; used_wval = '0;
        ram_waddr = AW'({r_disk, r_idx});
        ram_raddr = AW'({r_disk, r_idx});
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_item  = i_in_data;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // decide the item; out register is free here
                n_state = S_IDLE;
                n_ov    = 1'b1;
                n_out   = mk(ST_OK, 1'b0, CMD_NONE, '0, '0, '0, '0, 1'b1);
                case (r_item.operation)
                    OP_BEGIN: begin
                        if (r_commit || r_open == 6'd63 || !room) begin
                            n_out.status = ST_WAIT;
                        end else begin
                            n_open = r_open + 6'd1;
                        end
                    end
                    OP_END: begin
                        if (r_commit) begin
                            n_out.status = ST_ENDCOMMIT;
                        end else if (r_open == 6'd0) begin
                            n_out.status = ST_OUTSIDE;
                        end else begin
                            n_open = r_open - 6'd1;
                            if (r_open == 6'd1) begin
                                n_commit = 1'b1;
                                n_out.commit_required = 1'b1;
                            end
                        end
                    end
                    OP_RECORD: begin
                        if (!dev_ok) begin
                            n_out.status = ST_BADDEV;
                        end else if (r_open == 6'd0) begin
                            n_out.status = ST_OUTSIDE;
                        end else if (r_used[dev_disk] >= SW'(LOG_ENTRIES)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            n_ov = 1'b0; n_disk = dev_disk; n_idx = '0;
                            n_state = S_SEARCH;
                        end
                    end
                    OP_CDISK: begin
                        if (!r_commit) begin
                            n_out.status = ST_NOTCOMMIT;
                        end else if (!dev_ok) begin
                            n_out.status = ST_BADDEV;
                        end else if (r_used[dev_disk] != '0) begin
                            n_ov = 1'b0; n_disk = dev_disk; n_idx = '0;
                            n_state = S_COPY;
                        end
                    end
                    OP_CFIN: begin
                        if (!r_commit) begin
                            n_out.status = ST_NOTCOMMIT;
                        end else begin
                            n_commit = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            S_SEARCH: begin
                // r_idx is the address issued; r_rd_pend marks data for r_idx-1
                if (r_rd_pend && ram_rdata == r_item.home_block) begin
                    n_ov = 1'b1;
                    n_out = mk(ST_OK, 1'b0, CMD_NONE, '0, '0, '0, '0, 1'b1);
                    n_state = S_IDLE;
                end else if (r_idx == cur_used) begin
                    ram_we = 1'b1;
                    ram_waddr = AW'({r_disk, cur_used});
                    used_we = 1'b1;
                    used_wval = cur_used + SW'(1);
                    n_ov = 1'b1;
                    n_out = mk(ST_OK, 1'b0, CMD_PIN, r_item.device,
                               base + 32'(cur_used) + 32'd1,
                               r_item.home_block, '0, 1'b1);
                    n_state = S_IDLE;
                end else begin
                    n_rd_pend = 1'b1;
                    n_idx = r_idx + SW'(1);
                end
            end
            S_COPY, S_INSTALL: begin
                // issue read of r_idx, emit it once the data is back and the output frees
                if (r_rd_pend) begin
                    if (out_free) begin
                        n_ov = 1'b1;
                        n_out = mk(ST_OK, 1'b0,
                                   (r_state == S_COPY) ? CMD_COPY : CMD_INSTALL,
                                   r_item.device, base + 32'(r_idx) + 32'd1,
                                   ram_rdata, '0, 1'b0);
                        n_idx = r_idx + SW'(1);
                    end else begin
                        n_rd_pend = 1'b1; // hold; re-read same address
                    end
                end else if (r_idx == cur_used) begin
                    if (out_free) begin
                        n_ov = 1'b1;
                        n_idx = '0;
                        if (r_state == S_COPY) begin
                            n_out = mk(ST_OK, 1'b0, CMD_HEAD, r_item.device, base,
                                       '0, cur_used, 1'b0);
                            n_state = S_INSTALL;
                        end else begin
                            n_out = mk(ST_OK, 1'b0, CMD_CLEAR, r_item.device, base,
                                       '0, '0, 1'b1);
                            used_we = 1'b1;
                            used_wval = '0;
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_rd_pend = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_open   <= '0;
            r_commit <= 1'b0;
            r_rd_pend <= 1'b0;
            for (int d = 0; d < DISKS; d++) r_used[d] <= '0;
            for (int d = 0; d < MAX_DISKS; d++) r_log_start[d] <= 32'd2;
            r_max_op <= 5'd10;
        end else begin
            r_state  <= n_state;
            r_ov     <= n_ov;
            r_open   <= n_open;
            r_commit <= n_commit;
            r_rd_pend <= n_rd_pend;
            if (used_we) r_used[r_disk] <= used_wval;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LOG0:  r_log_start[0] <= i_cfg_data;
                    REG_LOG1:  r_log_start[1] <= i_cfg_data;
                    REG_LOG2:  r_log_start[2] <= i_cfg_data;
                    REG_LOG3:  r_log_start[3] <= i_cfg_data;
                    REG_MAXOP: r_max_op <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_disk <= n_disk;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end
endmodule

// File: sv/walm_checker.sv
// ----------------------------------------------------------------------------
// walm_props
// Port-level checks of the log manager, bound to the top level.
// ----------------------------------------------------------------------------
module walm_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input walm_pkg::t_out_item o_out_data
);
    import walm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");
    a_req_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.commit_required |-> o_out_data.last)
        else $error("commit request not on last result");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.command == CMD_NONE |->
        o_out_data.log_block == '0 && o_out_data.last)
        else $error("empty command carries data");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input taken mid item");
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid)
        else $error("input transfer dropped before acceptance");
endmodule

bind write_ahead_log_transaction_manager walm_props u_walm_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out_data(o_out_data)
);

// File: bench/walm_checker.sv
// ----------------------------------------------------------------------------
// walm_checker
// Watches both channels of the log manager, predicts every result transfer
// from the accepted input items and compares them field by field.
// ----------------------------------------------------------------------------
module walm_checker #(
    parameter int LOG_ENTRIES  = walm_pkg::LOG_ENTRIES_DEF,
    parameter int DISKS        = walm_pkg::DISKS_DEF,
    parameter int FIRST_DEVICE = walm_pkg::FIRST_DEVICE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  walm_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  walm_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    import walm_pkg::*;

    logic [31:0] log_base [MAX_DISKS];
    logic [4:0]  op_reserve;
    logic [5:0]  open_ops;
    logic        committing;
    logic [4:0]  fill [MAX_DISKS];
    logic [31:0] dirty [MAX_DISKS][32];
    t_out_item   expected_cmds [$];

    assign o_pending = expected_cmds.size();

    function automatic t_out_item mk(logic [2:0] st, logic req, logic [2:0] cmd,
                                     logic [3:0] dev, logic [31:0] lb,
                                     logic [31:0] tb, logic [4:0] cnt);
        t_out_item r;
        r.status = st; r.commit_required = req; r.command = cmd;
        r.command_device = dev; r.log_block = lb; r.target_block = tb;
        r.entry_count = cnt; r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_item(t_in_item it);
        t_out_item res [$];
        int d;
        int n;
        bit hold;
        bit found;
        logic [2:0] st;
        logic req;
        t_out_item r;
        d = int'(it.device) - FIRST_DEVICE;
        if (d >= DISKS) d = -1;
        case (it.operation)
            OP_BEGIN: begin
                hold = committing || open_ops >= 6'd63;
                for (int k = 0; k < DISKS; k++)
                    if (int'(fill[k]) + (int'(open_ops) + 1) * int'(op_reserve) > LOG_ENTRIES)
                        hold = 1;
                if (!hold) open_ops++;
                res.push_back(mk(hold ? ST_WAIT : ST_OK, 0, CMD_NONE, 0, 0, 0, 0));
            end
            OP_END: begin
                req = 0;
                if (committing) st = ST_ENDCOMMIT;
                else if (open_ops == 0) st = ST_OUTSIDE;
                else begin
                    st = ST_OK;
                    open_ops--;
                    if (open_ops == 0) begin
                        committing = 1;
                        req = 1;
                    end
                end
                res.push_back(mk(st, req, CMD_NONE, 0, 0, 0, 0));
            end
            OP_RECORD: begin
                if (d < 0) res.push_back(mk(ST_BADDEV, 0, CMD_NONE, 0, 0, 0, 0));
                else if (open_ops == 0) res.push_back(mk(ST_OUTSIDE, 0, CMD_NONE, 0, 0, 0, 0));
                else if (fill[d] >= LOG_ENTRIES || fill[d] >= 31)
                    res.push_back(mk(ST_FULL, 0, CMD_NONE, 0, 0, 0, 0));
                else begin
                    found = 0;
                    for (int k = 0; k < int'(fill[d]); k++)
                        if (dirty[d][k] == it.home_block) found = 1;
                    if (found) res.push_back(mk(ST_OK, 0, CMD_NONE, 0, 0, 0, 0));
                    else begin
                        dirty[d][fill[d]] = it.home_block;
                        res.push_back(mk(ST_OK, 0, CMD_PIN, it.device,
                                         log_base[d] + fill[d] + 1, it.home_block, 0));
                        fill[d]++;
                    end
                end
            end
            OP_CDISK: begin
                if (!committing) res.push_back(mk(ST_NOTCOMMIT, 0, CMD_NONE, 0, 0, 0, 0));
                else if (d < 0) res.push_back(mk(ST_BADDEV, 0, CMD_NONE, 0, 0, 0, 0));
                else if (fill[d] == 0) res.push_back(mk(ST_OK, 0, CMD_NONE, 0, 0, 0, 0));
                else begin
                    n = fill[d];
                    for (int k = 0; k < n; k++)
                        res.push_back(mk(ST_OK, 0, CMD_COPY, it.device,
                                         log_base[d] + k + 1, dirty[d][k], 0));
                    res.push_back(mk(ST_OK, 0, CMD_HEAD, it.device, log_base[d], 0, n[4:0]));
                    for (int k = 0; k < n; k++)
                        res.push_back(mk(ST_OK, 0, CMD_INSTALL, it.device,
                                         log_base[d] + k + 1, dirty[d][k], 0));
                    res.push_back(mk(ST_OK, 0, CMD_CLEAR, it.device, log_base[d], 0, 0));
                    fill[d] = 0;
                end
            end
            OP_CFIN: begin
                if (!committing) res.push_back(mk(ST_NOTCOMMIT, 0, CMD_NONE, 0, 0, 0, 0));
                else begin
                    committing = 0;
                    res.push_back(mk(ST_OK, 0, CMD_NONE, 0, 0, 0, 0));
                end
            end
            default: res.push_back(mk(ST_OK, 0, CMD_NONE, 0, 0, 0, 0));
        endcase
        res[res.size() - 1].last = 1'b1;
        foreach (res[k]) expected_cmds.push_back(res[k]);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_DISKS; k++) begin
                log_base[k] = 32'd2;
                fill[k] = '0;
            end
            op_reserve = 5'd10;
            open_ops = '0;
            committing = 1'b0;
            expected_cmds.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index < REG_MAXOP) log_base[i_cfg_index] = i_cfg_data;
                else if (i_cfg_index == REG_MAXOP) op_reserve = i_cfg_data[4:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_cmds.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, want, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_item(i_in_data);
        end
    end

endmodule

// File: bench/tb_write_ahead_log_transaction_manager.sv
// ----------------------------------------------------------------------------
// tb_write_ahead_log_transaction_manager
// Drives directed and random transaction sequences into the log manager
// under bursty input and stalling output; a checker scores every result.
// ----------------------------------------------------------------------------
module tb_write_ahead_log_transaction_manager;
    import walm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    int          errors;
    int          pending;
    int          burst_left = 0;
    int          stall_mode = 0;

    always #5 i_clk = ~i_clk;

    write_ahead_log_transaction_manager u_top (.*);

    walm_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_data(o_out_data),
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: phases of always-ready, light and heavy stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send(logic [2:0] op, logic [3:0] dev, logic [31:0] home);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= '{operation: op, device: dev, home_block: home};
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
        // the block is busy for the next cycle anyway
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [3:0] rnd_dev();
        return ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 2));
    endfunction

    function automatic logic [31:0] rnd_home();
        return ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 12));
    endfunction

    task automatic transaction();
        int ops;
        ops = $urandom_range(1, 3);
        for (int k = 0; k < ops; k++) send(OP_BEGIN, 0, 0);
        repeat ($urandom_range(0, 8)) send(OP_RECORD, rnd_dev(), rnd_home());
        for (int k = 0; k < ops; k++) send(OP_END, 0, 0);
        if ($urandom_range(0, 4) != 0) send(OP_CDISK, 4'd1, 0);
        if ($urandom_range(0, 4) != 0) send(OP_CDISK, 4'd2, 0);
        send(OP_CFIN, 0, 0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: errors outside a transaction, then extremes of every field
        send(OP_END, 0, 0);
        send(OP_RECORD, 4'd1, 32'd5);
        send(OP_CDISK, 4'd1, 0);
        send(OP_CFIN, 0, 0);
        send(3'd5, 4'hf, 32'hffff_ffff);
        send(3'd7, 0, 0);
        send(OP_BEGIN, 0, 0);
        send(OP_RECORD, 4'd0, 32'd1);
        send(OP_RECORD, 4'd15, 32'd1);
        send(OP_RECORD, 4'd1, 32'hffff_ffff);
        send(OP_RECORD, 4'd1, 32'hffff_ffff);
        send(OP_RECORD, 4'd2, 32'd0);
        send(OP_BEGIN, 0, 0);
        send(OP_BEGIN, 0, 0);
        send(OP_BEGIN, 0, 0);
        send(OP_END, 0, 0);
        send(OP_END, 0, 0);
        send(OP_END, 0, 0);
        send(OP_BEGIN, 0, 0);
        send(OP_END, 0, 0);
        send(OP_CDISK, 4'd0, 0);
        send(OP_CDISK, 4'd1, 0);
        send(OP_CDISK, 4'd2, 0);
        send(OP_CFIN, 0, 0);
        drain();
        // one op reserving a single entry: fill a log and saturate the count
        write_reg(REG_LOG0, 32'hffff_fff0);
        write_reg(REG_LOG1, 32'h0);
        write_reg(REG_LOG2, 32'h1234_5678);
        write_reg(REG_LOG3, 32'hffff_ffff);
        write_reg(REG_MAXOP, 32'd1);
        send(OP_BEGIN, 0, 0);
        for (int k = 0; k < 31; k++) send(OP_RECORD, 4'd1, 32'(k * 7));
        send(OP_BEGIN, 0, 0);
        send(OP_END, 0, 0);
        send(OP_CDISK, 4'd1, 0);
        send(OP_CFIN, 0, 0);
        drain();
        write_reg(REG_MAXOP, 32'd0);
        for (int k = 0; k < 64; k++) send(OP_BEGIN, 0, 0);
        for (int k = 0; k < 64; k++) send(OP_END, 0, 0);
        send(OP_CFIN, 0, 0);
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(REG_LOG0, $urandom);
            write_reg(REG_LOG1, (phase == 1) ? 32'hffff_ffff : $urandom);
            write_reg(REG_MAXOP, (phase == 3) ? 32'd31 : 32'($urandom_range(1, 12)));
            for (int k = 0; k < 20; k++) begin
                if ($urandom_range(0, 4) == 0)
                    send(3'($urandom), 4'($urandom), $urandom);
                else if ($urandom_range(0, 9) == 0)
                    transaction();
                else
                    send(3'($urandom_range(0, 4)), rnd_dev(), rnd_home());
            end
            // close any open work so the next settings apply to an idle block
            while (u_chk.open_ops != 6'd0) send(OP_END, 0, 0);
            send(OP_CDISK, 4'd1, 0);
            send(OP_CDISK, 4'd2, 0);
            send(OP_CFIN, 0, 0);
            drain();
            transaction();
            drain();
        end
        drain();
        if (errors == 0) $display("tb_write_ahead_log_transaction_manager passed");
        else $display("tb_write_ahead_log_transaction_manager failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_write_ahead_log_transaction_manager failed");
        $finish;
    end

endmodule

// File: write_ahead_log_transaction_manager.f
sv/walm_pkg.sv
sv/walm_ram.sv
sv/write_ahead_log_transaction_manager.sv
sv/walm_checker.sv
bench/walm_checker.sv
bench/tb_write_ahead_log_transaction_manager.sv
